>>> src/ocbhf_pkg.sv
// Shared types and constants for the overlap-cluster best-hit filter.
`default_nettype none
package ocbhf_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int FIELD_OFF_W     = 32;
    localparam int LEN_W           = 16;
    localparam int CFG_W           = 16;
    localparam int SCORE_W         = 32;
    localparam int COUNT_W         = 32;
    localparam int S_DATA_W        = FIELD_OFF_W + LEN_W + CFG_W + SCORE_W;
    localparam int M_DATA_W        = FIELD_OFF_W + LEN_W + CFG_W + SCORE_W + COUNT_W;
    localparam int RES_DEPTH       = 4;
    localparam int RES_PTR_W       = $clog2(RES_DEPTH);
    localparam int RES_CNT_W       = $clog2(RES_DEPTH + 1);
    localparam int MAX_PUSH        = 2;

    typedef struct packed {
        logic                   list_done;
        logic                   run_end;
        logic [COUNT_W-1:0]     detect_number;
        logic signed [SCORE_W-1:0] best_score;
        logic [CFG_W-1:0]       best_config;
        logic [LEN_W-1:0]       best_length;
        logic [FIELD_OFF_W-1:0] best_offset;
    } res_t;

    // Results written to the queue together: r0 first, then r1.
    typedef struct packed {
        logic [1:0] n;
        res_t       r1;
        res_t       r0;
    } push_t;

endpackage : ocbhf_pkg
`default_nettype wire

>>> src/ocbhf_fifo.sv
// Result queue with two write slots per cycle and one read port.
`default_nettype none
module ocbhf_fifo
    import ocbhf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output res_t       out_item
);

    res_t                 mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wp_reg, wp_next;
    logic [RES_PTR_W-1:0] rp_reg, rp_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 pop;
    logic [RES_PTR_W-1:0] wp_plus1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rp_reg];
    // room for a full pair of results
    assign room      = (cnt_reg <= RES_CNT_W'(RES_DEPTH - MAX_PUSH));
    assign wp_plus1  = wp_reg + RES_PTR_W'(1);

    always_comb begin
        wp_next  = wp_reg + RES_PTR_W'(push.n);
        rp_next  = pop ? rp_reg + RES_PTR_W'(1) : rp_reg;
        cnt_next = cnt_reg + RES_CNT_W'(push.n) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem[wp_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem[wp_plus1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule : ocbhf_fifo
`default_nettype wire

>>> src/ocbhf_core.sv
// Input register, cluster state and the per-hit join/keep/emit decision.
`default_nettype none
module ocbhf_core
    import ocbhf_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   direction,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FIELD_OFF_W-1:0] in_offset,
    input  wire logic [LEN_W-1:0]       in_length,
    input  wire logic [CFG_W-1:0]       in_config,
    input  wire logic [SCORE_W-1:0]     in_score,
    input  wire logic                   in_final,
    input  wire logic                   room,
    output push_t                       push
);

    localparam int SUM_W = OFFSET_BITS + 1;

    // input register
    logic                      hv_reg;
    logic [OFFSET_BITS-1:0]    h_off_reg;
    logic [LEN_W-1:0]          h_len_reg;
    logic [CFG_W-1:0]          h_cfg_reg;
    logic signed [SCORE_W-1:0] h_sc_reg;
    logic                      h_fin_reg;

    // cluster state
    logic                      open_reg, open_next;
    logic [OFFSET_BITS-1:0]    a_off_reg, a_off_next;
    logic [LEN_W-1:0]          a_len_reg, a_len_next;
    logic [OFFSET_BITS-1:0]    k_off_reg, k_off_next;
    logic [LEN_W-1:0]          k_len_reg, k_len_next;
    logic [CFG_W-1:0]          k_cfg_reg, k_cfg_next;
    logic signed [SCORE_W-1:0] k_sc_reg, k_sc_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;

    logic                      proc;
    logic [SUM_W-1:0]          fwd_end;
    logic [SUM_W-1:0]          rev_end;
    logic                      joins;
    logic                      close_old;
    logic                      take_hit;
    logic                      restart;
    logic [COUNT_W-1:0]        c1;
    logic [COUNT_W-1:0]        c2;

    assign in_ready = !hv_reg || room;
    assign proc     = hv_reg && room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg <= 1'b0;
        end else if (in_ready) begin
            hv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            h_off_reg <= OFFSET_BITS'(in_offset);
            h_len_reg <= in_length;
            h_cfg_reg <= in_config;
            h_sc_reg  <= signed'(in_score);
            h_fin_reg <= in_final;
        end
    end

    // overlap sums carry one extra bit so they never wrap
    assign fwd_end = SUM_W'(a_off_reg) + SUM_W'(a_len_reg);
    assign rev_end = SUM_W'(h_off_reg) + SUM_W'(h_len_reg);
    assign joins   = direction ? (rev_end > SUM_W'(a_off_reg))
                               : (SUM_W'(h_off_reg) < fwd_end);

    assign close_old = open_reg && !joins;
    assign restart   = !open_reg || !joins;
    // earliest hit wins a tie
    assign take_hit  = restart || (h_sc_reg > k_sc_reg);

    assign c1 = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNT_W'(1);
    assign c2 = (c1 == '1) ? c1 : c1 + COUNT_W'(1);

    always_comb begin
        k_off_next = take_hit ? h_off_reg : k_off_reg;
        k_len_next = take_hit ? h_len_reg : k_len_reg;
        k_cfg_next = take_hit ? h_cfg_reg : k_cfg_reg;
        k_sc_next  = take_hit ? h_sc_reg  : k_sc_reg;
        a_off_next = restart ? h_off_reg : a_off_reg;
        a_len_next = restart ? h_len_reg : a_len_reg;
        open_next  = !h_fin_reg;
        if (h_fin_reg) begin
            cnt_next = '0;
        end else if (close_old) begin
            cnt_next = c1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_comb begin
        push.n = proc ? (2'(close_old) + 2'(h_fin_reg)) : 2'd0;

        // first result: the closed cluster, or the flush when nothing closed
        push.r0.best_offset   = FIELD_OFF_W'(close_old ? k_off_reg : k_off_next);
        push.r0.best_length   = close_old ? k_len_reg : k_len_next;
        push.r0.best_config   = close_old ? k_cfg_reg : k_cfg_next;
        push.r0.best_score    = close_old ? k_sc_reg  : k_sc_next;
        push.r0.detect_number = c1;
        push.r0.run_end       = !(close_old && h_fin_reg);
        push.r0.list_done     = !close_old;

        // second result: flush of the cluster just opened
        push.r1.best_offset   = FIELD_OFF_W'(k_off_next);
        push.r1.best_length   = k_len_next;
        push.r1.best_config   = k_cfg_next;
        push.r1.best_score    = k_sc_next;
        push.r1.detect_number = c2;
        push.r1.run_end       = 1'b1;
        push.r1.list_done     = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (proc) begin
            open_reg <= open_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            a_off_reg <= a_off_next;
            a_len_reg <= a_len_next;
            k_off_reg <= k_off_next;
            k_len_reg <= k_len_next;
            k_cfg_reg <= k_cfg_next;
            k_sc_reg  <= k_sc_next;
        end
    end

endmodule : ocbhf_core
`default_nettype wire

>>> src/overlap_cluster_best_hit_filter.sv
// Top level of the overlap-cluster best-hit filter.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  s_      | in        | s_tvalid / s_tready   | s_tdata hit fields, s_tlast final_hit
//  m_      | out       | m_tvalid / m_tready   | m_tdata best hit, m_tlast/m_tuser flags
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_data direction
//
// One hit per cycle is accepted while the queue has room; a hit is decided in the
// input register and its 0, 1 or 2 results enter a four-entry result queue.
// The input side stalls only while the queue cannot take a pair of results.
// Results pass through the input register and the result queue before reaching m_.
// aresetn is synchronous, active low; it closes the cluster, clears the detection
// count and empties the queue. Config writes are always ready.
`default_nettype none
module overlap_cluster_best_hit_filter
    import ocbhf_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data,   // [0] direction
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [31:0] hit_offset, [47:32] hit_length, [63:48] hit_config, [95:64] hit_score
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tlast,    // final_hit
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [31:0] best_offset, [47:32] best_length, [63:48] best_config,
    // [95:64] best_score, [127:96] detect_number
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tlast,    // run_end
    output logic                     m_tuser     // [0] list_done
);

    logic  direction_reg;
    logic  room;
    push_t push;
    res_t  head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
        end else if (cfg_valid) begin
            direction_reg <= cfg_data;
        end
    end

    ocbhf_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .direction (direction_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_offset (s_tdata[31:0]),
        .in_length (s_tdata[47:32]),
        .in_config (s_tdata[63:48]),
        .in_score  (s_tdata[95:64]),
        .in_final  (s_tlast),
        .room      (room),
        .push      (push)
    );

    ocbhf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {head.detect_number, head.best_score, head.best_config,
                      head.best_length, head.best_offset};
    assign m_tlast = head.run_end;
    assign m_tuser = head.list_done;

endmodule : overlap_cluster_best_hit_filter
`default_nettype wire
